// File: rtl/core/dsu_pkg.sv
// Package for the disjoint-set block: table size, field widths and controller states.
// No dependencies; disjoint_set_union_find imports it, while dsu_ram does not.
package dsu_pkg;

  localparam int unsigned MAX_ELEMS = 1024;
  localparam int unsigned ELEM_W    = 11;
  localparam int unsigned ADDR_W    = $clog2(MAX_ELEMS);

  typedef logic [ELEM_W-1:0] elem_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam elem_t MAX_ELEMS_E = elem_t'(MAX_ELEMS);
  localparam addr_t LAST_ADDR   = addr_t'(MAX_ELEMS - 1);

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_WALK_A,
    ST_WALK_B
  } dsu_state_e;

endpackage

// File: rtl/core/disjoint_set_union_find.sv
// Top level of the disjoint-set (union-find) block: controller, parent table and result registers.
// Depends on dsu_pkg and dsu_ram.
//
//   channel   | handshake             | payload
//   ----------+-----------------------+-------------------------------------------------
//   request   | start (in), busy (out)| req_type_i, elem_a_i, elem_b_i
//   result    | done_o (out, 1 cycle) | root_a_o, root_b_o, same_set_o, merged_o,
//             |                       | range_error_o
//   config    | cfg_we_i              | cfg_wdata_i (elems_in_use)
//
// An item with an out-of-range element gives its result in the cycle after acceptance.
// Otherwise the block reads the parent table once per hop, one hop per cycle, walking the
// first element's chain to its root and then the second's, through the single read port.
// Reset: after rst_ni releases, the parent table is swept to identity, one entry a cycle,
// over all MAX_ELEMS entries, with busy high; configuration writes are taken during the sweep.
// Stalls: the receiver cannot stall; done_o is high for a single cycle, other outputs hold.
module disjoint_set_union_find (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  logic          req_type_i,
  input  dsu_pkg::elem_t elem_a_i,
  input  dsu_pkg::elem_t elem_b_i,
  input  logic          cfg_we_i,
  input  dsu_pkg::elem_t cfg_wdata_i,
  output logic          done_o,
  output dsu_pkg::elem_t root_a_o,
  output dsu_pkg::elem_t root_b_o,
  output logic          same_set_o,
  output logic          merged_o,
  output logic          range_error_o
);

  import dsu_pkg::*;

  dsu_state_e state_q, state_d;
  addr_t      init_q, init_d;
  elem_t      elems_q;
  elem_t      cur_q, cur_d;       // element whose parent is being read
  elem_t      ra_q, ra_d;         // root of the first element once found
  elem_t      b_q, b_d;           // second element, held until its walk starts
  logic       merge_q, merge_d;

  logic       done_q, done_d;
  elem_t      root_a_q, root_a_d;
  elem_t      root_b_q, root_b_d;
  logic       same_q, same_d;
  logic       merged_q, merged_d;
  logic       err_q, err_d;

  // table port signals
  logic       ram_we;
  addr_t      ram_waddr;
  elem_t      ram_wdata;
  elem_t      rd_elem;            // element number to look up; address is element minus one
  elem_t      rd_elem_m1;
  elem_t      ra_m1;
  elem_t      parent;

  elem_t      limit;
  logic       req_err;
  logic       at_root;

  // An element count above the table acts as the table size.
  assign limit   = (elems_q > MAX_ELEMS_E) ? MAX_ELEMS_E : elems_q;
  assign req_err = (elem_a_i == '0) || (elem_a_i > limit) ||
                   (elem_b_i == '0) || (elem_b_i > limit);
  // A root is self-parented: the entry just read names the element itself.
  assign at_root = (parent == cur_q);

  assign rd_elem_m1 = rd_elem - elem_t'(1);
  assign ra_m1      = ra_q - elem_t'(1);

  dsu_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (MAX_ELEMS)
  ) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_elem_m1[ADDR_W-1:0]),
    .rdata_o (parent)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (init_q == LAST_ADDR) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start && !req_err) state_d = ST_WALK_A;
      end
      ST_WALK_A: begin
        if (at_root) state_d = ST_WALK_B;
      end
      ST_WALK_B: begin
        if (at_root) state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  // Datapath, table access and result registers.
  always_comb begin
    init_d    = init_q;
    cur_d     = cur_q;
    ra_d      = ra_q;
    b_d       = b_q;
    merge_d   = merge_q;
    done_d    = 1'b0;
    root_a_d  = root_a_q;
    root_b_d  = root_b_q;
    same_d    = same_q;
    merged_d  = merged_q;
    err_d     = err_q;
    ram_we    = 1'b0;
    ram_waddr = init_q;
    ram_wdata = elem_t'(init_q) + elem_t'(1);
    rd_elem   = cur_q;
    unique case (state_q)
      ST_INIT: begin
        // sweep the table to identity
        ram_we = 1'b1;
        init_d = init_q + addr_t'(1);
      end
      ST_IDLE: begin
        rd_elem = elem_a_i;
        if (start) begin
          if (req_err) begin
            done_d   = 1'b1;
            root_a_d = '0;
            root_b_d = '0;
            same_d   = 1'b0;
            merged_d = 1'b0;
            err_d    = 1'b1;
          end else begin
            cur_d   = elem_a_i;
            b_d     = elem_b_i;
            merge_d = req_type_i;
          end
        end
      end
      ST_WALK_A: begin
        if (at_root) begin
          // first root found; start the second walk right away
          ra_d    = cur_q;
          rd_elem = b_q;
          cur_d   = b_q;
        end else begin
          rd_elem = parent;
          cur_d   = parent;
        end
      end
      ST_WALK_B: begin
        if (at_root) begin
          done_d   = 1'b1;
          root_a_d = ra_q;
          root_b_d = cur_q;
          same_d   = (ra_q == cur_q);
          merged_d = merge_q && (ra_q != cur_q);
          err_d    = 1'b0;
          // link the first root under the second; done before the next item can read
          if (merge_q && (ra_q != cur_q)) begin
            ram_we    = 1'b1;
            ram_waddr = ra_m1[ADDR_W-1:0];
            ram_wdata = cur_q;
          end
        end else begin
          rd_elem = parent;
          cur_d   = parent;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      init_q  <= '0;
      elems_q <= MAX_ELEMS_E;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        elems_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    ra_q     <= ra_d;
    b_q      <= b_d;
    merge_q  <= merge_d;
    root_a_q <= root_a_d;
    root_b_q <= root_b_d;
    same_q   <= same_d;
    merged_q <= merged_d;
    err_q    <= err_d;
  end

  assign busy          = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign root_a_o      = root_a_q;
  assign root_b_o      = root_b_q;
  assign same_set_o    = same_q;
  assign merged_o      = merged_q;
  assign range_error_o = err_q;

endmodule

// File: rtl/core/dsu_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module dsu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
